FILE: rtl/xs128_pkg.sv
// Package for the xorshift128 step-and-reverse block: opcodes, widths and
// the command/status structs between controller and datapath. No dependencies.
package xs128_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned COUNT_BITS = 16;  // up to STEP_BITS
  localparam int unsigned STEP_BITS  = 16;
  localparam int unsigned OP_BITS    = 3;
  localparam int unsigned HALF_BITS  = 2 * WORD_BITS;

  // s_axis tdata: seed_high, seed_low, step_count
  localparam int unsigned IN_DATA_BITS  = 2 * HALF_BITS + STEP_BITS;
  // m_axis tdata: random_word, state_high, state_low
  localparam int unsigned OUT_DATA_BITS = WORD_BITS + 2 * HALF_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_NEXT    = 3'd0,
    OP_PREV    = 3'd1,
    OP_LOAD    = 3'd2,
    OP_ADVANCE = 3'd3,
    OP_REWIND  = 3'd4
  } xs_op_e;

  typedef struct packed {
    logic load_seed;
    logic load_count;
    logic step_fwd;
    logic step_back;
    logic dec_count;
  } xs_cmd_t;

  typedef struct packed {
    logic count_zero;
  } xs_stat_t;

endpackage

FILE: rtl/xs128_ctrl.sv
// Controller FSM for the xorshift128 block: input/output handshakes and
// step sequencing for advance/rewind. Depends on xs128_pkg.
module xs128_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [xs128_pkg::OP_BITS-1:0] opcode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output xs128_pkg::xs_cmd_t            cmd_o,
  input  xs128_pkg::xs_stat_t           stat_i
);
  import xs128_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   back_q;      // rewind in progress
  logic   accept;
  logic   run_op;      // advance or rewind

  // result is the live state, so a new beat is taken only once the old one leaves
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign run_op      = (xs_op_e'(opcode_i) == OP_ADVANCE) ||
                       (xs_op_e'(opcode_i) == OP_REWIND);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (xs_op_e'(opcode_i))
            OP_NEXT:    cmd_o.step_fwd   = 1'b1;
            OP_PREV:    cmd_o.step_back  = 1'b1;
            OP_LOAD:    cmd_o.load_seed  = 1'b1;
            OP_ADVANCE: cmd_o.load_count = 1'b1;
            OP_REWIND:  cmd_o.load_count = 1'b1;
            default:    cmd_o = '0;
          endcase
        end
      end
      ST_RUN: begin
        if (!stat_i.count_zero) begin
          cmd_o.step_fwd  = !back_q;
          cmd_o.step_back = back_q;
          cmd_o.dec_count = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      back_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // any pending result leaves at this same edge
            if (run_op) begin
              state_q     <= ST_RUN;
              back_q      <= (xs_op_e'(opcode_i) == OP_REWIND);
              out_valid_q <= 1'b0;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_RUN: begin
          if (stat_i.count_zero) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/xs128_dp.sv
// Datapath for the xorshift128 block: the four generator words, the forward
// and inverse step logic and the step counter. Depends on xs128_pkg.
module xs128_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  xs128_pkg::xs_cmd_t              cmd_i,
  output xs128_pkg::xs_stat_t             stat_o,
  input  logic [xs128_pkg::HALF_BITS-1:0] seed_high_i,
  input  logic [xs128_pkg::HALF_BITS-1:0] seed_low_i,
  input  logic [xs128_pkg::STEP_BITS-1:0] step_count_i,
  output logic [xs128_pkg::WORD_BITS-1:0] random_word_o,
  output logic [xs128_pkg::HALF_BITS-1:0] state_high_o,
  output logic [xs128_pkg::HALF_BITS-1:0] state_low_o
);
  import xs128_pkg::*;

  logic [WORD_BITS-1:0]  w0_q, w1_q, w2_q, w3_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [WORD_BITS-1:0]  fwd_t, fwd_w, back_x0, back_x1, back_x2, back_x3, back_w;

  // forward: t = w0 ^ (w0 << 11); w3' = t ^ (t >> 8) ^ w3 ^ (w3 >> 19)
  assign fwd_t = w0_q ^ (w0_q << 11);
  assign fwd_w = fwd_t ^ (fwd_t >> 8) ^ w3_q ^ (w3_q >> 19);

  // inverse: undo the right shift by 8, then the left shift by 11
  assign back_x0 = (w2_q >> 19) ^ w2_q ^ w3_q;
  assign back_x1 = back_x0 ^ (back_x0 >> 8);
  assign back_x2 = back_x1 ^ (back_x1 >> 16);
  assign back_x3 = back_x2 ^ (back_x2 << 11);
  assign back_w  = back_x3 ^ (back_x3 << 22);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q    <= '0;
      w1_q    <= '0;
      w2_q    <= '0;
      w3_q    <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.load_seed) begin
        w0_q <= seed_high_i[HALF_BITS-1:WORD_BITS];
        w1_q <= seed_high_i[WORD_BITS-1:0];
        w2_q <= seed_low_i[HALF_BITS-1:WORD_BITS];
        w3_q <= seed_low_i[WORD_BITS-1:0];
      end else if (cmd_i.step_fwd) begin
        w0_q <= w1_q;
        w1_q <= w2_q;
        w2_q <= w3_q;
        w3_q <= fwd_w;
      end else if (cmd_i.step_back) begin
        w0_q <= back_w;
        w1_q <= w0_q;
        w2_q <= w1_q;
        w3_q <= w2_q;
      end
      if (cmd_i.load_count) begin
        count_q <= step_count_i[COUNT_BITS-1:0];
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - COUNT_BITS'(1);
      end
    end
  end

  assign stat_o.count_zero = (count_q == '0);
  assign random_word_o     = w3_q;
  assign state_high_o      = {w0_q, w1_q};
  assign state_low_o       = {w2_q, w3_q};

endmodule

FILE: rtl/xorshift128_step_and_reverse.sv
// xorshift128 generator (shifts 11, 8, 19) with next, prev, load, advance and
// rewind. Top level: stream ports around the xs128_ctrl FSM and xs128_dp datapath.
// Depends on xs128_pkg.
//
// Usage: one result beat for every input beat, always reporting the state after
// the operation. For next, prev, load and unused opcodes the result appears
// the cycle after acceptance. advance and rewind load the step counter on
// acceptance and give the result once it reaches zero; the datapath applies one
// generator step per cycle under the step counter. The result is the live
// state, so the next input beat is accepted in the cycle its predecessor's
// result is taken; back-to-back single steps thus run at one per cycle when
// the output side is always ready. The state resets to zero, which is a fixed
// point: load a seed first.
module xorshift128_step_and_reverse (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [63:0] seed_high, [127:64] seed_low, [143:128] step_count
  input  logic [xs128_pkg::IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // [2:0] opcode
  input  logic [xs128_pkg::OP_BITS-1:0]       s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] random_word, [95:32] state_high, [159:96] state_low
  output logic [xs128_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o
);
  import xs128_pkg::*;

  xs_cmd_t              cmd;
  xs_stat_t             stat;
  logic [WORD_BITS-1:0] random_word;
  logic [HALF_BITS-1:0] state_high;
  logic [HALF_BITS-1:0] state_low;

  xs128_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .opcode_i    (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  xs128_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .seed_high_i   (s_axis_tdata_i[HALF_BITS-1:0]),
    .seed_low_i    (s_axis_tdata_i[2*HALF_BITS-1:HALF_BITS]),
    .step_count_i  (s_axis_tdata_i[IN_DATA_BITS-1:2*HALF_BITS]),
    .random_word_o (random_word),
    .state_high_o  (state_high),
    .state_low_o   (state_low)
  );

  assign m_axis_tdata_o = {state_low, state_high, random_word};

endmodule
